[rtl/isqrt_pkg.sv]
// Shared constants for the integer square root block.
// No dependencies; compile before the interfaces and the top level.
package isqrt_pkg;

    // Operand bits consumed per root bit (one base-4 digit)
    localparam int unsigned DIGIT_W = 2;

    // Reset value of the signed-mode register
    localparam logic SIGNED_MODE_RST = 1'b0;

endpackage

[rtl/isqrt_if.sv]
// Valid/ready channel interfaces for the integer square root block.
// Uses isqrt_pkg; compile after the package and before the top level.

// Operand channel
interface isqrt_in_if
    import isqrt_pkg::*;
#(
    parameter int unsigned WIDTH = 32
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] operand;

    modport source (output valid, output operand, input ready);
    modport sink   (input valid, input operand, output ready);
endinterface

// Result channel
interface isqrt_out_if
    import isqrt_pkg::*;
#(
    parameter int unsigned ROOT_W = 16
);
    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root;
    logic              rejected;

    modport source (output valid, output root, output rejected, input ready);
    modport sink   (input valid, input root, input rejected, output ready);
endinterface

[rtl/integer_square_root.sv]
// Top level of the integer square root block: floor(sqrt(operand)).
// Depends on isqrt_pkg and the channel interfaces in isqrt_if.sv.

// Computes floor(sqrt(operand)) for a WIDTH-bit operand with a restoring
// digit-by-digit method: the operand sits in a shift register that hands
// two bits per cycle to a narrow remainder/compare stage, which yields one
// root bit per cycle. One transaction is processed at a time. An accepted
// operand is loaded, runs through the root loop for one root bit per digit
// and then moves into the output register once that register is free or
// being drained; a new operand is taken only after that move. A negative
// operand in signed mode skips the loop and returns root 0 with rejected
// set. The output register lets the next operand enter while a result
// still waits to be taken. signed_mode is written through i_cfg_we /
// i_cfg_wdata and should only change while the block is idle.
module integer_square_root
    import isqrt_pkg::*;
#(
    parameter int unsigned WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    isqrt_in_if.sink    i_in,
    isqrt_out_if.source o_out
);

    localparam int unsigned ROOT_W = (WIDTH + 1) / 2;
    localparam int unsigned PAD_W = DIGIT_W * ROOT_W;   // operand padded to whole digits
    localparam int unsigned REM_W = ROOT_W + 1;         // remainder <= 2*root
    localparam int unsigned SH_W  = REM_W + DIGIT_W;    // remainder with next digit
    localparam int unsigned CNT_W = $clog2(ROOT_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } t_state;

    t_state            r_state;
    logic              r_signed_mode;
    logic [PAD_W-1:0]  r_opnd;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic              r_rej;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [ROOT_W-1:0] r_out_root;
    logic              r_out_rej;

    logic [SH_W-1:0]   n_rem_sh;
    logic [SH_W:0]     n_diff;
    logic              n_borrow;
    logic [REM_W-1:0]  n_rem;
    logic [ROOT_W-1:0] n_root;
    logic              n_neg;
    logic              in_fire;

    // Handshake
    assign i_in.ready     = (r_state == ST_IDLE);
    assign in_fire        = i_in.valid && (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.root     = r_out_root;
    assign o_out.rejected = r_out_rej;

    assign n_neg = r_signed_mode && i_in.operand[WIDTH-1];

    // One root bit: bring in the next digit, try subtracting 4*root+1
    always_comb begin
        n_rem_sh = {r_rem, r_opnd[PAD_W-1 -: DIGIT_W]};
        n_diff   = {1'b0, n_rem_sh} - {2'b00, r_root, 2'b01};
        n_borrow = n_diff[SH_W];
        if (n_borrow) begin
            n_rem = n_rem_sh[REM_W-1:0];
        end else begin
            n_rem = n_diff[REM_W-1:0];
        end
        n_root = {r_root[ROOT_W-2:0], ~n_borrow};
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= SIGNED_MODE_RST;
        end else if (i_cfg_we) begin
            r_signed_mode <= i_cfg_wdata;
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            // Drain; in ST_WAIT a drained register is refilled below
            if (r_out_valid && o_out.ready && r_state != ST_WAIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_opnd  <= PAD_W'(i_in.operand);
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_rej   <= n_neg;
                        r_count <= CNT_W'(ROOT_W - 1);
                        r_state <= n_neg ? ST_WAIT : ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_opnd  <= r_opnd << DIGIT_W;
                    r_rem   <= n_rem;
                    r_root  <= n_root;
                    r_count <= r_count - 1'b1;
                    if (r_count == '0) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_root  <= r_root;
                        r_out_rej   <= r_rej;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // A rejected result never carries a root
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rej) |-> (r_out_root == '0))
        else $error("rejected result with nonzero root");

    // Restoring invariant: remainder never exceeds twice the partial root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_rem <= {r_root, 1'b0}))
        else $error("remainder out of range");

    // Loop ends after the last root bit
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_count == '0) |=> (r_state == ST_WAIT))
        else $error("root loop did not terminate");

    // A negative operand goes straight to the output stage
    a_neg_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_neg) |=> (r_state == ST_WAIT && r_rej))
        else $error("negative operand not rejected");

    // Output register only loads when free or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT && r_out_valid && !o_out.ready) |=> (r_state == ST_WAIT))
        else $error("result overwritten before it was taken");

endmodule

[bench/integer_square_root_tb.sv]
// Self-checking testbench for integer_square_root: floor(sqrt(operand)) with signed mode.
// Depends on isqrt_pkg, the channel interfaces in isqrt_if.sv and the integer_square_root RTL.
// A scoreboard predicts each root as operands are accepted and checks results in order.
module integer_square_root_tb;
    import isqrt_pkg::*;

    localparam int unsigned WIDTH      = 32;
    localparam int unsigned ROOT_W     = (WIDTH + 1) / 2;
    localparam int unsigned DRAIN_CYC  = ROOT_W + 8;
    localparam int unsigned ITEMS      = 120;
    localparam longint      TIMEOUT_TU = 64'd3200000;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic              rejected;
    } t_root_result;

    // Expected roots, in the order the operands were accepted
    class root_scoreboard;
        t_root_result pending_roots[$];
        int unsigned  mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Restoring digit-by-digit root: one root bit per base-4 digit of the operand
        function logic [ROOT_W-1:0] floor_root(logic [WIDTH-1:0] value);
            logic [63:0] rem;
            logic [63:0] acc;
            logic [63:0] digit;
            rem   = 64'(value);
            acc   = '0;
            digit = 64'd1 << (DIGIT_W * (ROOT_W - 1));
            while (digit != 0) begin
                if (rem >= acc + digit) begin
                    rem = rem - (acc + digit);
                    acc = (acc >> 1) + digit;
                end else begin
                    acc = acc >> 1;
                end
                digit = digit >> DIGIT_W;
            end
            return acc[ROOT_W-1:0];
        endfunction

        // Accepted operand: work out the root it must produce
        function void note_operand(logic [WIDTH-1:0] operand, logic signed_mode);
            t_root_result want;
            if (signed_mode && operand[WIDTH-1]) begin
                want.root     = '0;
                want.rejected = 1'b1;
            end else begin
                want.root     = floor_root(operand);
                want.rejected = 1'b0;
            end
            pending_roots.push_back(want);
        endfunction

        // Accepted result: compare with the oldest pending root
        function void check_result(logic [ROOT_W-1:0] root, logic rejected);
            t_root_result want;
            if (pending_roots.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual root %0d rejected %0b",
                         $time, root, rejected);
                return;
            end
            want = pending_roots.pop_front();
            if (root !== want.root) begin
                mismatches++;
                $display("%0t: root mismatch, expected %0d, actual %0d",
                         $time, want.root, root);
            end
            if (rejected !== want.rejected) begin
                mismatches++;
                $display("%0t: rejected mismatch, expected %0b, actual %0b",
                         $time, want.rejected, rejected);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    isqrt_in_if  #(.WIDTH(WIDTH))   op_ch ();
    isqrt_out_if #(.ROOT_W(ROOT_W)) res_ch ();

    integer_square_root #(
        .WIDTH (WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (op_ch),
        .o_out       (res_ch)
    );

    root_scoreboard sb = new();

    // Shadow of the signed-mode register, only changed while idle
    logic        signed_mode_q = SIGNED_MODE_RST;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // 8-unit clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watch both channels; values seen here are the ones at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (op_ch.valid && op_ch.ready)
                sb.note_operand(op_ch.operand, signed_mode_q);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.root, res_ch.rejected);
        end
    end

    // Present one operand and hold it until it is accepted
    task automatic send_operand(logic [WIDTH-1:0] value);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_ch.valid   <= 1'b1;
        op_ch.operand <= value;
        do @(posedge i_clk); while (!op_ch.ready);
    endtask

    // Stop sending, wait for every pending root, then let the pipeline settle
    task automatic wait_idle();
        op_ch.valid <= 1'b0;
        // Let the last accepted operand reach the scoreboard before polling it
        @(posedge i_clk);
        while (sb.pending_roots.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_signed_mode(logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        signed_mode_q = mode;
    endtask

    // Mix of full-range, small, near-square and top-bit-set operands
    function automatic logic [WIDTH-1:0] random_operand();
        logic [WIDTH-1:0] base;
        case ($urandom_range(0, 3))
            0: begin
                base = WIDTH'($urandom);
            end
            1: begin
                base = WIDTH'($urandom_range(0, 1023));
            end
            2: begin
                base = WIDTH'($urandom_range(0, (1 << ROOT_W) - 1));
                base = base * base + WIDTH'($urandom_range(0, 2)) - WIDTH'(1);
            end
            default: begin
                base = WIDTH'($urandom);
                base[WIDTH-1] = 1'b1;
            end
        endcase
        return base;
    endfunction

    task automatic run_random(int unsigned count, int unsigned send_pct,
                              int unsigned recv_pct, logic mode);
        write_signed_mode(mode);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_operand(random_operand());
        wait_idle();
    endtask

    // Main sequence
    initial begin
        logic [WIDTH-1:0] unsigned_cases[$];
        logic [WIDTH-1:0] signed_cases[$];
        op_ch.valid   <= 1'b0;
        op_ch.operand <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, small values, square edges and the top bit, reset mode
        unsigned_cases = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h4, 32'hF, 32'h10, 32'h11,
                           32'h3FFF_FFFF, 32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'hFFFE_0000, 32'hFFFE_0001, 32'hFFFF_FFFF};
        foreach (unsigned_cases[k])
            send_operand(unsigned_cases[k]);
        wait_idle();

        // Directed: negatives rejected, zero and positives still rooted
        write_signed_mode(1'b1);
        signed_cases = '{32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hC000_0000,
                         32'h7FFF_FFFF, 32'h1};
        foreach (signed_cases[k])
            send_operand(signed_cases[k]);
        wait_idle();

        // Random phases over idling patterns and both modes
        run_random(ITEMS, 0, 0, 1'b0);
        run_random(ITEMS, 78, 0, 1'b1);
        run_random(ITEMS, 0, 78, 1'b0);
        run_random(ITEMS, 37, 37, 1'b1);
        run_random(ITEMS, 0, 0, 1'b0);

        if (sb.mismatches == 0 && sb.pending_roots.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_TU);
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/isqrt_pkg.sv
rtl/isqrt_if.sv
rtl/integer_square_root.sv
bench/integer_square_root_tb.sv
